FILE: design/sysex_seven_bit_field_decoder_macros.svh
// assertion macros for the sysex field decoder top level
// no dependencies; included by files that carry concurrent assertions
`ifndef SYSEX_SEVEN_BIT_FIELD_DECODER_MACROS_SVH
`define SYSEX_SEVEN_BIT_FIELD_DECODER_MACROS_SVH

// same-cycle implication
`define SBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbd assertion failed");

// next-cycle implication
`define SBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbd assertion failed");

`endif

FILE: design/sbd_pkg.sv
// types, codes and helpers for the sysex seven bit field decoder
// no dependencies
`timescale 1ns / 1ps

package sbd_pkg;

   localparam int DIGIT_BITS          = 7;
   localparam int LONGEST_FIELD_BYTES = 8;
   localparam int ACC_BITS            = 56;
   localparam int VALUE_BITS          = ACC_BITS + 1;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_CHAR     = 3'd1;
   localparam logic [2:0] ST_STR_END  = 3'd2;
   localparam logic [2:0] ST_NON_DATA = 3'd3;
   localparam logic [2:0] ST_BAD_SIGN = 3'd4;
   localparam logic [2:0] ST_TRUNC    = 3'd5;

   localparam logic [2:0] MODE_U1     = 3'd0;
   localparam logic [2:0] MODE_U2     = 3'd1;
   localparam logic [2:0] MODE_U4     = 3'd2;
   localparam logic [2:0] MODE_U8     = 3'd3;
   localparam logic [2:0] MODE_S1     = 3'd4;
   localparam logic [2:0] MODE_S2     = 3'd5;
   localparam logic [2:0] MODE_S4     = 3'd6;
   localparam logic [2:0] MODE_STRING = 3'd7;

   localparam logic [1:0] CSR_POSITIVE_SIGN = 2'd0;
   localparam logic [1:0] CSR_NEGATIVE_SIGN = 2'd1;
   localparam logic [1:0] CSR_STRING_END    = 2'd2;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [2:0] mode;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] field_value;
      logic [2:0]                   status;
      logic [2:0]                   kind_done;
   } rsp_type;

   typedef struct packed {
      logic [6:0] positive_sign_code;
      logic [6:0] negative_sign_code;
      logic [6:0] string_end_code;
   } csr_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } step_out_type;

   function automatic logic [3:0] field_len(input logic [2:0] mode);
      logic [3:0] n;
      case (mode)
         MODE_U1, MODE_S1: n = 4'd1;
         MODE_U2, MODE_S2: n = 4'd2;
         MODE_U4, MODE_S4: n = 4'd4;
         MODE_U8:          n = 4'd8;
         default:          n = 4'd0;
      endcase
      if (n > 4'(LONGEST_FIELD_BYTES)) begin
         n = 4'(LONGEST_FIELD_BYTES);
      end
      return n;
   endfunction

endpackage

FILE: design/sbd_csr.sv
// configuration registers: sign codes and string terminator
// depends on sbd_pkg
`timescale 1ns / 1ps

module sbd_csr (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [6:0]    csr_data,
   output sbd_pkg::csr_type cfg
);

   sbd_pkg::csr_type cfg_ff;
   sbd_pkg::csr_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sbd_pkg::CSR_POSITIVE_SIGN: cfg_in.positive_sign_code = csr_data;
            sbd_pkg::CSR_NEGATIVE_SIGN: cfg_in.negative_sign_code = csr_data;
            sbd_pkg::CSR_STRING_END:    cfg_in.string_end_code    = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.positive_sign_code <= 7'd0;
         cfg_ff.negative_sign_code <= 7'd1;
         cfg_ff.string_end_code    <= 7'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/sbd_step.sv
// field state registers and the per-byte decode logic
// depends on sbd_pkg
`timescale 1ns / 1ps

module sbd_step (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  sbd_pkg::req_type       req,
   input  sbd_pkg::csr_type       cfg,
   output sbd_pkg::step_out_type  result
);

   logic                         in_field_ff, in_field_in;
   logic [2:0]                   kind_ff, kind_in;
   logic [3:0]                   left_ff, left_in;
   logic [sbd_pkg::ACC_BITS-1:0] acc_ff, acc_in;
   logic                         neg_ff, neg_in;
   logic                         await_ff, await_in;

   logic [2:0]                     kind_cur;
   logic [3:0]                     left_cur;
   logic [sbd_pkg::ACC_BITS-1:0]   acc_cur;
   logic                           neg_cur;
   logic                           await_cur;
   logic [sbd_pkg::VALUE_BITS-1:0] wide;

   always_comb begin
      kind_cur  = in_field_ff ? kind_ff : req.mode;
      left_cur  = in_field_ff ? left_ff : sbd_pkg::field_len(req.mode);
      acc_cur   = in_field_ff ? acc_ff : '0;
      neg_cur   = in_field_ff ? neg_ff : 1'b0;
      await_cur = in_field_ff ? await_ff
                              : (req.mode >= sbd_pkg::MODE_S1 &&
                                 req.mode <= sbd_pkg::MODE_S4);

      in_field_in = 1'b1;
      kind_in     = kind_cur;
      left_in     = left_cur;
      acc_in      = acc_cur;
      neg_in      = neg_cur;
      await_in    = await_cur;
      wide        = '0;

      result.valid            = 1'b0;
      result.data.field_value = '0;
      result.data.status      = sbd_pkg::ST_DONE;
      result.data.kind_done   = kind_cur;

      if (await_cur) begin
         await_in = 1'b0;
         if (req.rx_byte == {1'b0, cfg.negative_sign_code}) begin
            neg_in = 1'b1;
            if (req.end_of_message) begin
               result.valid       = 1'b1;
               result.data.status = sbd_pkg::ST_TRUNC;
            end
         end else if (req.rx_byte == {1'b0, cfg.positive_sign_code}) begin
            neg_in = 1'b0;
            if (req.end_of_message) begin
               result.valid       = 1'b1;
               result.data.status = sbd_pkg::ST_TRUNC;
            end
         end else begin
            result.valid       = 1'b1;
            result.data.status = sbd_pkg::ST_BAD_SIGN;
         end
      end else if (req.rx_byte[7]) begin
         result.valid       = 1'b1;
         result.data.status = sbd_pkg::ST_NON_DATA;
      end else if (kind_cur == sbd_pkg::MODE_STRING) begin
         if (req.rx_byte == {1'b0, cfg.string_end_code}) begin
            result.valid       = 1'b1;
            result.data.status = sbd_pkg::ST_STR_END;
         end else if (req.end_of_message) begin
            result.valid       = 1'b1;
            result.data.status = sbd_pkg::ST_TRUNC;
         end else begin
            result.valid            = 1'b1;
            result.data.status      = sbd_pkg::ST_CHAR;
            result.data.field_value = $signed(sbd_pkg::VALUE_BITS'(req.rx_byte));
         end
      end else begin
         acc_in = {acc_cur[sbd_pkg::ACC_BITS-sbd_pkg::DIGIT_BITS-1:0],
                   req.rx_byte[sbd_pkg::DIGIT_BITS-1:0]};
         if (left_cur != 4'd0) begin
            left_in = left_cur - 4'd1;
         end
         wide = {1'b0, acc_in};
         if (left_in == 4'd0) begin
            result.valid            = 1'b1;
            result.data.status      = sbd_pkg::ST_DONE;
            result.data.field_value = $signed(neg_cur ? (~wide + 1'b1) : wide);
         end else if (req.end_of_message) begin
            result.valid       = 1'b1;
            result.data.status = sbd_pkg::ST_TRUNC;
         end
      end

      if (result.valid) begin
         in_field_in = 1'b0;
         if (result.data.status != sbd_pkg::ST_CHAR) begin
            await_in = 1'b0;
         end
      end
      if (result.valid && result.data.status == sbd_pkg::ST_CHAR) begin
         in_field_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_field_ff <= 1'b0;
         kind_ff     <= '0;
         left_ff     <= '0;
         acc_ff      <= '0;
         neg_ff      <= 1'b0;
         await_ff    <= 1'b0;
      end else if (fire) begin
         in_field_ff <= in_field_in;
         kind_ff     <= kind_in;
         left_ff     <= left_in;
         acc_ff      <= acc_in;
         neg_ff      <= neg_in;
         await_ff    <= await_in;
      end
   end

endmodule

FILE: design/sysex_seven_bit_field_decoder.sv
// top level of the sysex seven bit field decoder: csr block, decode step, result register
// depends on sbd_pkg, sbd_csr, sbd_step and sysex_seven_bit_field_decoder_macros.svh
//
//   port group   direction   handshake          payload
//   req_         in          req_valid/stall    rx_byte, mode, end_of_message
//   rsp_         out         rsp_valid/stall    field_value, status, kind_done
//   csr_         in          csr_valid/ready    csr_index, csr_data
//
// one request per cycle unless req_stall is high; its result, if any, is registered
// field state and result register update in the same cycle as request acceptance
// req_stall is high only while a result is held and rsp_stall is high
// synchronous active-high reset clears field state and result valid and loads csr defaults
`timescale 1ns / 1ps
`include "sysex_seven_bit_field_decoder_macros.svh"

module sysex_seven_bit_field_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbd_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [6:0]       csr_data
);

   sbd_pkg::csr_type      cfg;
   sbd_pkg::step_out_type step_out;

   logic             fire;
   logic             rsp_valid_ff, rsp_valid_in;
   sbd_pkg::rsp_type rsp_data_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   sbd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sbd_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .req    (req_data),
      .cfg    (cfg),
      .result (step_out)
   );

   always_comb begin
      rsp_valid_in = fire ? step_out.valid : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_out.valid) begin
         rsp_data_ff <= step_out.data;
      end
   end

   `SBD_ASSERT_NOW(a_no_accept_when_blocked, clock, reset,
      rsp_valid_ff && rsp_stall, !fire)
   `SBD_ASSERT_NEXT(a_result_registered, clock, reset,
      fire && step_out.valid, rsp_valid_ff)
   `SBD_ASSERT_NOW(a_char_is_string, clock, reset,
      rsp_valid_ff && rsp_data_ff.status == sbd_pkg::ST_CHAR,
      rsp_data_ff.kind_done == sbd_pkg::MODE_STRING)
   `SBD_ASSERT_NOW(a_error_value_zero, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == sbd_pkg::ST_STR_END ||
                       rsp_data_ff.status == sbd_pkg::ST_NON_DATA ||
                       rsp_data_ff.status == sbd_pkg::ST_BAD_SIGN ||
                       rsp_data_ff.status == sbd_pkg::ST_TRUNC),
      rsp_data_ff.field_value == '0)

endmodule

FILE: sim/sysex_seven_bit_field_decoder_tb.sv
// self-checking testbench for sysex_seven_bit_field_decoder: directed table, then random fields
// depends on sbd_pkg and the decoder rtl; results come from typed table rows or an in-bench field decoder
`timescale 1ns / 1ps

module sysex_seven_bit_field_decoder_tb;

   localparam int CLOCK_PERIOD = 10;
   localparam int HOLD_CYCLES  = 60;

   typedef enum logic [1:0] {CHECK_DECODER, CHECK_TYPED} row_check_type;

   typedef struct packed {
      sbd_pkg::req_type req;
      row_check_type    check;
      sbd_pkg::rsp_type result;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   sbd_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   sbd_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [6:0]       csr_data;

   // decoder copy of the registers and field state
   logic [6:0]  code_positive;
   logic [6:0]  code_negative;
   logic [6:0]  code_string_end;
   logic        field_open;
   logic [2:0]  field_mode;
   logic [3:0]  digits_left;
   logic [55:0] field_acc;
   logic        field_negative;
   logic        sign_pending;

   sbd_pkg::rsp_type expected_fields [$];
   stim_row_type     directed_rows [$];
   sbd_pkg::rsp_type want;
   int      mismatches = 0;
   int      requests_sent = 0;
   int      sender_gap_pct = 0;
   int      receiver_stall_pct = 0;
   int      holds_asked = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   sysex_seven_bit_field_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic expect_result(input sbd_pkg::rsp_type res);
      expected_fields = {expected_fields, res};
   endtask

   task automatic decode_request(input sbd_pkg::req_type r, output logic produced,
                                 output sbd_pkg::rsp_type res);
      logic        done;
      logic [2:0]  st;
      logic [56:0] v;
      done = 1'b0;
      st = sbd_pkg::ST_DONE;
      v = '0;
      produced = 1'b0;
      res = '0;
      if (!field_open) begin
         field_open = 1'b1;
         field_mode = r.mode;
         case (r.mode)
            sbd_pkg::MODE_U1, sbd_pkg::MODE_S1: digits_left = 4'd1;
            sbd_pkg::MODE_U2, sbd_pkg::MODE_S2: digits_left = 4'd2;
            sbd_pkg::MODE_U4, sbd_pkg::MODE_S4: digits_left = 4'd4;
            sbd_pkg::MODE_U8:                   digits_left = 4'd8;
            default:                            digits_left = 4'd0;
         endcase
         field_acc = '0;
         field_negative = 1'b0;
         sign_pending = (r.mode >= sbd_pkg::MODE_S1 && r.mode <= sbd_pkg::MODE_S4);
      end
      if (sign_pending) begin
         if (r.rx_byte == {1'b0, code_negative}) begin
            field_negative = 1'b1;
         end else if (r.rx_byte == {1'b0, code_positive}) begin
            field_negative = 1'b0;
         end else begin
            done = 1'b1;
            st = sbd_pkg::ST_BAD_SIGN;
         end
         if (!done) begin
            sign_pending = 1'b0;
            if (r.end_of_message) begin
               done = 1'b1;
               st = sbd_pkg::ST_TRUNC;
            end
         end
      end else if (r.rx_byte[7]) begin
         done = 1'b1;
         st = sbd_pkg::ST_NON_DATA;
      end else if (field_mode == sbd_pkg::MODE_STRING) begin
         if (r.rx_byte[6:0] == code_string_end) begin
            done = 1'b1;
            st = sbd_pkg::ST_STR_END;
         end else if (r.end_of_message) begin
            done = 1'b1;
            st = sbd_pkg::ST_TRUNC;
         end else begin
            produced = 1'b1;
            res.field_value = 57'(r.rx_byte);
            res.status = sbd_pkg::ST_CHAR;
            res.kind_done = field_mode;
         end
      end else begin
         field_acc = {field_acc[48:0], r.rx_byte[6:0]};
         if (digits_left != 0) begin
            digits_left = digits_left - 4'd1;
         end
         if (digits_left == 0) begin
            done = 1'b1;
            st = sbd_pkg::ST_DONE;
            v = field_negative ? 57'd0 - {1'b0, field_acc} : {1'b0, field_acc};
         end else if (r.end_of_message) begin
            done = 1'b1;
            st = sbd_pkg::ST_TRUNC;
         end
      end
      if (done) begin
         produced = 1'b1;
         res.field_value = v;
         res.status = st;
         res.kind_done = field_mode;
         field_open = 1'b0;
         sign_pending = 1'b0;
      end
   endtask

   task automatic send_request(input sbd_pkg::req_type r);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   task automatic send_random_field();
      logic [2:0]       mode;
      logic [7:0]       bytes_q [$];
      logic [7:0]       b;
      int               count;
      int               roll;
      sbd_pkg::req_type r;
      logic             produced;
      sbd_pkg::rsp_type res;
      mode = 3'($urandom_range(7));
      roll = $urandom_range(99);
      if (roll < 8) begin
         bytes_q = {bytes_q, 8'($urandom)};
      end else begin
         if (mode >= sbd_pkg::MODE_S1 && mode <= sbd_pkg::MODE_S4) begin
            roll = $urandom_range(99);
            if (roll < 45) begin
               bytes_q = {bytes_q, {1'b0, code_negative}};
            end else if (roll < 90) begin
               bytes_q = {bytes_q, {1'b0, code_positive}};
            end else begin
               bytes_q = {bytes_q, 8'($urandom)};
            end
         end
         case (mode)
            sbd_pkg::MODE_U1, sbd_pkg::MODE_S1: count = 1;
            sbd_pkg::MODE_U2, sbd_pkg::MODE_S2: count = 2;
            sbd_pkg::MODE_U4, sbd_pkg::MODE_S4: count = 4;
            sbd_pkg::MODE_U8:                   count = 8;
            default:                            count = $urandom_range(6);
         endcase
         for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
               b = 8'h80 | 8'($urandom);
            end else if (roll < 10) begin
               b = 8'h7f;
            end else if (roll < 16) begin
               b = 8'h00;
            end else begin
               b = {1'b0, 7'($urandom)};
            end
            bytes_q = {bytes_q, b};
         end
         if (mode == sbd_pkg::MODE_STRING && $urandom_range(9) != 0) begin
            bytes_q = {bytes_q, {1'b0, code_string_end}};
         end
      end
      foreach (bytes_q[i]) begin
         r.rx_byte = bytes_q[i];
         r.mode = (i == 0) ? mode : 3'($urandom_range(7));
         r.end_of_message = ($urandom_range(99) < ((i == bytes_q.size() - 1) ? 25 : 3));
         send_request(r);
         decode_request(r, produced, res);
         if (produced) begin
            expect_result(res);
         end
      end
   endtask

   task automatic send_random_fields(input int n);
      int first;
      first = requests_sent;
      while (requests_sent - first < n) begin
         send_random_field();
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic set_codes(input logic [6:0] pos, input logic [6:0] neg,
                            input logic [6:0] term);
      write_csr(sbd_pkg::CSR_POSITIVE_SIGN, pos);
      write_csr(sbd_pkg::CSR_NEGATIVE_SIGN, neg);
      write_csr(sbd_pkg::CSR_STRING_END, term);
      csr_valid <= 1'b0;
      code_positive = pos;
      code_negative = neg;
      code_string_end = term;
   endtask

   task automatic add_row(input logic [7:0] b, input logic [2:0] m, input logic eom,
                          input row_check_type c, input logic [56:0] v,
                          input logic [2:0] st, input logic [2:0] k);
      stim_row_type s;
      s.req.rx_byte = b;
      s.req.mode = m;
      s.req.end_of_message = eom;
      s.check = c;
      s.result.field_value = v;
      s.result.status = st;
      s.result.kind_done = k;
      directed_rows = {directed_rows, s};
   endtask

   // response side: stall pattern, long hold-off on request, field checks
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_fields.size() == 0) begin
               $error("result with no request pending: status %0d", rsp_data.status);
               mismatches++;
            end else begin
               want = expected_fields.pop_front();
               if (rsp_data.field_value !== want.field_value) begin
                  $error("field_value: expected %0d, got %0d",
                         want.field_value, rsp_data.field_value);
                  mismatches++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  mismatches++;
               end
               if (rsp_data.kind_done !== want.kind_done) begin
                  $error("kind_done: expected %0d, got %0d",
                         want.kind_done, rsp_data.kind_done);
                  mismatches++;
               end
            end
         end
         if (hold_left == 0 && holds_served != holds_asked) begin
            hold_left = HOLD_CYCLES;
            holds_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   initial begin
      logic             produced;
      sbd_pkg::rsp_type res;
      logic [6:0]       same_code;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= sbd_pkg::CSR_POSITIVE_SIGN;
      csr_data <= '0;
      code_positive = 7'd0;
      code_negative = 7'd1;
      code_string_end = 7'd0;
      field_open = 1'b0;
      field_mode = '0;
      digits_left = '0;
      field_acc = '0;
      field_negative = 1'b0;
      sign_pending = 1'b0;

      add_row(8'h7f, sbd_pkg::MODE_U1, 1'b0, CHECK_TYPED, 57'd127, sbd_pkg::ST_DONE,
              sbd_pkg::MODE_U1);
      add_row(8'h00, sbd_pkg::MODE_U1, 1'b1, CHECK_TYPED, 57'd0, sbd_pkg::ST_DONE,
              sbd_pkg::MODE_U1);
      add_row(8'h80, sbd_pkg::MODE_U2, 1'b0, CHECK_TYPED, 57'd0, sbd_pkg::ST_NON_DATA,
              sbd_pkg::MODE_U2);
      repeat (7) begin
         add_row(8'h7f, sbd_pkg::MODE_U8, 1'b0, CHECK_DECODER, '0, '0, '0);
      end
      add_row(8'h7f, sbd_pkg::MODE_U8, 1'b0, CHECK_TYPED, 57'h0ff_ffff_ffff_ffff,
              sbd_pkg::ST_DONE, sbd_pkg::MODE_U8);
      add_row(8'h01, sbd_pkg::MODE_S1, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h7f, sbd_pkg::MODE_STRING, 1'b0, CHECK_TYPED, -57'sd127, sbd_pkg::ST_DONE,
              sbd_pkg::MODE_S1);
      add_row(8'h55, sbd_pkg::MODE_S2, 1'b0, CHECK_TYPED, 57'd0, sbd_pkg::ST_BAD_SIGN,
              sbd_pkg::MODE_S2);
      add_row(8'h81, sbd_pkg::MODE_S1, 1'b0, CHECK_TYPED, 57'd0, sbd_pkg::ST_BAD_SIGN,
              sbd_pkg::MODE_S1);
      add_row(8'h00, sbd_pkg::MODE_S1, 1'b1, CHECK_TYPED, 57'd0, sbd_pkg::ST_TRUNC,
              sbd_pkg::MODE_S1);
      add_row(8'h00, sbd_pkg::MODE_S4, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h12, sbd_pkg::MODE_U1, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h34, sbd_pkg::MODE_U1, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h56, sbd_pkg::MODE_U1, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h7b, sbd_pkg::MODE_U1, 1'b0, CHECK_DECODER, '0, '0, '0);
      add_row(8'h41, sbd_pkg::MODE_STRING, 1'b0, CHECK_TYPED, 57'h41, sbd_pkg::ST_CHAR,
              sbd_pkg::MODE_STRING);
      add_row(8'hff, sbd_pkg::MODE_U1, 1'b0, CHECK_TYPED, 57'd0, sbd_pkg::ST_NON_DATA,
              sbd_pkg::MODE_STRING);
      add_row(8'h42, sbd_pkg::MODE_STRING, 1'b1, CHECK_TYPED, 57'd0, sbd_pkg::ST_TRUNC,
              sbd_pkg::MODE_STRING);
      add_row(8'h00, sbd_pkg::MODE_STRING, 1'b0, CHECK_TYPED, 57'd0, sbd_pkg::ST_STR_END,
              sbd_pkg::MODE_STRING);
      add_row(8'h01, sbd_pkg::MODE_U4, 1'b1, CHECK_TYPED, 57'd0, sbd_pkg::ST_TRUNC,
              sbd_pkg::MODE_U4);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_gap_pct = 30;
      receiver_stall_pct = 74;
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req);
         decode_request(directed_rows[i].req, produced, res);
         case (directed_rows[i].check)
            CHECK_DECODER: begin
               if (produced) begin
                  expect_result(res);
               end
            end
            CHECK_TYPED: begin
               expect_result(directed_rows[i].result);
            end
            default: begin
            end
         endcase
      end
      wait_idle();

      set_codes(7'd127, 7'd0, 7'd127);
      send_random_fields(80);
      wait_idle();

      sender_gap_pct = 74;
      receiver_stall_pct = 30;
      set_codes(7'd0, 7'd127, 7'd0);
      send_random_fields(80);
      wait_idle();

      // equal sign codes, with a long result hold-off while requests keep coming
      same_code = 7'($urandom);
      set_codes(same_code, same_code, 7'($urandom));
      holds_asked++;
      send_random_fields(80);
      wait_idle();

      sender_gap_pct = 0;
      receiver_stall_pct = 0;
      repeat (2) begin
         set_codes(7'($urandom), 7'($urandom), 7'($urandom));
         send_random_fields(80);
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_fields.size() == 0) begin
         $display("sysex_seven_bit_field_decoder test passed");
      end else begin
         $display("sysex_seven_bit_field_decoder test failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("sysex_seven_bit_field_decoder test failed");
      $finish;
   end

endmodule
